[rtl/xcd_pkg.sv]
// Shared types and constants for the XOR-checked command deframer.
// Used by the top level; has no dependencies of its own.
`timescale 1ns / 1ps

package xcd_pkg;

	// Command opcode
	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_READ    = 1'b1
	} op_t;

	// Packet kind selected by the first byte
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_STD   = 2'd1,
		KIND_MID   = 2'd2,
		KIND_SHORT = 2'd3
	} kind_t;

	// Register indexes on the configuration port (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_STD_SIG    = 3'd0,
		REG_MID_SIG    = 3'd1,
		REG_SHORT_SIG  = 3'd2,
		REG_HDR_SEED   = 3'd3,
		REG_DATA_SEED  = 3'd4
	} reg_idx_t;

	localparam int CFG_ADDR_W = 5;

	// Register reset values
	localparam logic [7:0] STD_SIG_RESET   = 8'd1;
	localparam logic [7:0] MID_SIG_RESET   = 8'd2;
	localparam logic [7:0] SHORT_SIG_RESET = 8'd246;
	localparam logic [7:0] HDR_SEED_RESET  = 8'd0;
	localparam logic [7:0] DATA_SEED_RESET = 8'd0;

	// Packet geometry
	localparam logic [8:0] STD_HEADER_BYTES   = 9'd6;
	localparam logic [8:0] MID_PACKET_BYTES   = 9'd4;
	localparam logic [8:0] SHORT_PACKET_BYTES = 9'd2;
	localparam logic [8:0] MAX_PACKET_BYTES   = 9'd262;

	// Byte positions within a frame
	localparam logic [8:0] POS_SIG     = 9'd0;
	localparam logic [8:0] POS_ADDR_HI = 9'd1;
	localparam logic [8:0] POS_ADDR_LO = 9'd2;
	localparam logic [8:0] POS_ID      = 9'd3;
	localparam logic [8:0] POS_LEN     = 9'd4;
	localparam logic [8:0] POS_HCHK    = 9'd5;
	localparam logic [8:0] POS_DATA    = 9'd6;

	localparam logic [7:0] HCHK_RESET = 8'hFF;

	// Request carried from the input stage to the result register
	typedef struct packed {
		logic       is_read;
		logic       done;
		logic [8:0] size;
		logic [8:0] latched;
		logic       in_range;
		logic       from_src;
	} stage_t;

endpackage

[rtl/xor_checked_command_deframer.sv]
// Top level of the XOR-checked command deframer.
// Depends on xcd_pkg and xcd_ram.
`timescale 1ns / 1ps

// Usage
// Command channel (cmd_valid/cmd_ready): opcode 0 feeds one received byte
// (rx_byte) into the framer, opcode 1 reads byte read_index of the last
// latched packet. Each command gives exactly one response on the response
// channel (rsp_valid/rsp_ready): packet_done/packet_size for a byte that
// completes a good packet, read_byte for a read, latched_size always.
// rsp_valid rises when a command moves from the input stage into the result
// register; one command is taken per cycle while cmd_ready is high. A good
// packet is kept in a ping-pong pair of receive banks and copied into the
// latched store in the background, one byte per cycle; reads that hit bytes
// not yet copied are served from the source bank. cmd_ready drops when the
// input stage is held, or while the copy engine is busy and the next received
// byte could complete another packet, as when a short packet follows a long one.
// Reset clears framing state, the latched size and restores the registers;
// stores need no clearing. A stalled receiver holds the response register,
// and one more command is still taken into the input stage before
// cmd_ready falls.
// Registers: std_signature 0x00, mid_signature 0x04, short_signature 0x08,
// header_check_seed 0x0C, data_check_seed 0x10.

module xor_checked_command_deframer
	import xcd_pkg::*;
#(
	parameter int STORE_DEPTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// command channel
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  logic                  opcode,
	input  logic [7:0]            rx_byte,
	input  logic [8:0]            read_index,
	// response channel
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  packet_done,
	output logic [8:0]            packet_size,
	output logic [7:0]            read_byte,
	output logic [8:0]            latched_size
);

	localparam int AW       = $clog2(STORE_DEPTH);
	localparam int RX_DEPTH = 2 * (2 ** AW);

	// Configuration registers
	logic [7:0] std_sig_q, mid_sig_q, short_sig_q, hdr_seed_q, data_seed_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	// Framing state
	logic [8:0] pos_q, pos_n, pos_inc;
	logic [8:0] exp_q, exp_n;
	kind_t      kind_q, kind_n;
	logic [7:0] hc_q, hc_n;
	logic [7:0] dc_q, dc_n, dc_x;
	logic [7:0] first_q;
	logic [8:0] lcount_q;
	logic       wbank_q;
	logic       latch, restart, latch_arm;
	logic [8:0] lat_size;

	// Copy engine
	logic       cp_busy_q, cp_src_q, cp_wen_q;
	logic [8:0] cp_rd_q, cp_wr_q, cp_size_q;
	logic       cp_issue;
	logic [7:0] cp_rdata;

	// Pipeline
	logic       accept, rx_accept, rd_accept, advance;
	logic       valid_s1;
	stage_t     st_s1;
	logic       in_range;
	logic       from_src;
	logic [7:0] look_rdata, lat_rdata;
	logic       done_q;
	logic [8:0] size_q, lsize_q;
	logic [7:0] rbyte_q;
	logic       rsp_valid_q;

	// Register access
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_sig_q   <= STD_SIG_RESET;
			mid_sig_q   <= MID_SIG_RESET;
			short_sig_q <= SHORT_SIG_RESET;
			hdr_seed_q  <= HDR_SEED_RESET;
			data_seed_q <= DATA_SEED_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_STD_SIG:   std_sig_q   <= pwdata[7:0];
				REG_MID_SIG:   mid_sig_q   <= pwdata[7:0];
				REG_SHORT_SIG: short_sig_q <= pwdata[7:0];
				REG_HDR_SEED:  hdr_seed_q  <= pwdata[7:0];
				REG_DATA_SEED: data_seed_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STD_SIG:   prdata = {24'd0, std_sig_q};
			REG_MID_SIG:   prdata = {24'd0, mid_sig_q};
			REG_SHORT_SIG: prdata = {24'd0, short_sig_q};
			REG_HDR_SEED:  prdata = {24'd0, hdr_seed_q};
			REG_DATA_SEED: prdata = {24'd0, data_seed_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Handshake: the input stage advances into the result register
	assign advance   = valid_s1 & (~rsp_valid_q | rsp_ready);
	assign latch_arm = ((pos_q == POS_ADDR_HI) && (kind_q == KIND_SHORT))
		|| ((pos_q == POS_ID) && (kind_q == KIND_MID))
		|| ((pos_q >= POS_DATA) && (pos_inc >= exp_q));
	assign cmd_ready = (~valid_s1 | advance) & ~(cp_busy_q & latch_arm);
	assign accept    = cmd_valid & cmd_ready;
	assign rx_accept = accept & (op_t'(opcode) == OP_RECEIVE);
	assign rd_accept = accept & (op_t'(opcode) == OP_READ);

	// Next framing state for one received byte
	assign pos_inc = pos_q + 9'd1;
	assign dc_x    = dc_q ^ rx_byte;

	always_comb begin
		pos_n    = pos_q;
		exp_n    = exp_q;
		kind_n   = kind_q;
		hc_n     = hc_q;
		dc_n     = dc_q;
		latch    = 1'b0;
		restart  = 1'b0;
		lat_size = 9'd0;
		case (pos_q)
			POS_SIG: begin
				if (rx_byte == std_sig_q) begin
					kind_n = KIND_STD;
					exp_n  = STD_HEADER_BYTES;
					hc_n   = hdr_seed_q;
					pos_n  = POS_ADDR_HI;
				end else if (rx_byte == mid_sig_q) begin
					kind_n = KIND_MID;
					exp_n  = MID_PACKET_BYTES;
					hc_n   = hdr_seed_q;
					pos_n  = POS_ADDR_HI;
				end else if (rx_byte == short_sig_q) begin
					kind_n = KIND_SHORT;
					exp_n  = SHORT_PACKET_BYTES;
					hc_n   = hdr_seed_q;
					pos_n  = POS_ADDR_HI;
				end
			end
			POS_ADDR_HI: begin
				if (kind_q == KIND_SHORT) begin
					if (rx_byte != first_q) begin
						restart = 1'b1;
					end else begin
						latch    = 1'b1;
						lat_size = SHORT_PACKET_BYTES;
					end
				end else begin
					hc_n  = hc_q ^ rx_byte;
					pos_n = POS_ADDR_LO;
				end
			end
			POS_ADDR_LO: begin
				hc_n  = hc_q ^ rx_byte;
				pos_n = POS_ID;
			end
			POS_ID: begin
				if (kind_q == KIND_MID) begin
					if (rx_byte != hc_q) begin
						restart = 1'b1;
					end else begin
						latch    = 1'b1;
						lat_size = MID_PACKET_BYTES;
					end
				end else begin
					hc_n  = hc_q ^ rx_byte;
					pos_n = POS_LEN;
				end
			end
			POS_LEN: begin
				exp_n = STD_HEADER_BYTES + {1'b0, rx_byte} + 9'd1;
				hc_n  = hc_q ^ rx_byte;
				pos_n = POS_HCHK;
			end
			POS_HCHK: begin
				if (rx_byte != hc_q) begin
					restart = 1'b1;
				end else begin
					dc_n  = data_seed_q;
					pos_n = POS_DATA;
				end
			end
			default: begin
				// data bytes; packets never reach the store depth
				dc_n  = dc_x;
				pos_n = pos_inc;
				if (pos_inc >= exp_q) begin
					if (dc_x != 8'd0) begin
						restart = 1'b1;
					end else begin
						latch    = 1'b1;
						lat_size = pos_inc;
					end
				end
			end
		endcase
		if (restart || latch) begin
			pos_n  = POS_SIG;
			exp_n  = 9'd0;
			kind_n = KIND_NONE;
			hc_n   = HCHK_RESET;
			dc_n   = 8'd0;
		end
	end

	// Hold framing state; flip the receive bank on each latched packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_SIG;
			exp_q    <= 9'd0;
			kind_q   <= KIND_NONE;
			hc_q     <= HCHK_RESET;
			dc_q     <= 8'd0;
			lcount_q <= 9'd0;
			wbank_q  <= 1'b0;
		end else if (rx_accept) begin
			pos_q  <= pos_n;
			exp_q  <= exp_n;
			kind_q <= kind_n;
			hc_q   <= hc_n;
			dc_q   <= dc_n;
			if (latch) begin
				lcount_q <= lat_size;
				wbank_q  <= ~wbank_q;
			end
		end
	end

	// Keep the first byte for the short-packet repeat check
	always_ff @(posedge clk) begin
		if (rx_accept && (pos_q == POS_SIG)) begin
			first_q <= rx_byte;
		end
	end

	// Copy engine: move a latched packet from its receive bank, one byte a cycle
	assign cp_issue = cp_busy_q & (cp_rd_q < cp_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_busy_q <= 1'b0;
			cp_src_q  <= 1'b0;
			cp_wen_q  <= 1'b0;
			cp_rd_q   <= 9'd0;
			cp_wr_q   <= 9'd0;
			cp_size_q <= 9'd0;
		end else if (rx_accept && latch) begin
			cp_busy_q <= 1'b1;
			cp_src_q  <= wbank_q;
			cp_wen_q  <= 1'b0;
			cp_rd_q   <= 9'd0;
			cp_wr_q   <= 9'd0;
			cp_size_q <= lat_size;
		end else if (cp_busy_q) begin
			cp_wen_q <= cp_issue;
			if (cp_issue) begin
				cp_rd_q <= cp_rd_q + 9'd1;
			end
			if (cp_wen_q) begin
				cp_wr_q <= cp_wr_q + 9'd1;
				if ((cp_wr_q + 9'd1) == cp_size_q) begin
					cp_busy_q <= 1'b0;
				end
			end
		end
	end

	// Receive bank, read by the copy engine
	xcd_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_copy (
		.clk   (clk),
		.we    (rx_accept),
		.waddr ({wbank_q, AW'(pos_q)}),
		.wdata (rx_byte),
		.re    (cp_issue),
		.raddr ({cp_src_q, AW'(cp_rd_q)}),
		.rdata (cp_rdata)
	);

	// Duplicate receive bank, read by lookups of bytes not yet copied
	xcd_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_look (
		.clk   (clk),
		.we    (rx_accept),
		.waddr ({wbank_q, AW'(pos_q)}),
		.wdata (rx_byte),
		.re    (rd_accept),
		.raddr ({cp_src_q, AW'(read_index)}),
		.rdata (look_rdata)
	);

	// Latched packet store
	xcd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_latched (
		.clk   (clk),
		.we    (cp_wen_q),
		.waddr (AW'(cp_wr_q)),
		.wdata (cp_rdata),
		.re    (rd_accept),
		.raddr (AW'(read_index)),
		.rdata (lat_rdata)
	);

	// Pick the source of a read: bytes between the copy pointer and the size
	assign in_range = (32'(read_index) < 32'(STORE_DEPTH));
	assign from_src = cp_busy_q & (read_index >= cp_wr_q) & (read_index < cp_size_q);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1.is_read  <= (op_t'(opcode) == OP_READ);
			st_s1.done     <= rx_accept & latch;
			st_s1.size     <= rx_accept ? lat_size : 9'd0;
			st_s1.latched  <= (rx_accept && latch) ? lat_size : lcount_q;
			st_s1.in_range <= in_range;
			st_s1.from_src <= from_src;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q  <= st_s1.done;
			size_q  <= st_s1.size;
			lsize_q <= st_s1.latched;
			if (st_s1.is_read && st_s1.in_range) begin
				rbyte_q <= st_s1.from_src ? look_rdata : lat_rdata;
			end else begin
				rbyte_q <= 8'd0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign packet_done  = done_q;
	assign packet_size  = size_q;
	assign read_byte    = rbyte_q;
	assign latched_size = lsize_q;

	// A new copy never starts over one in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_accept && latch) |-> !cp_busy_q)
		else $error("copy started while busy");

	// Copy pointers stay ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		cp_busy_q |-> ((cp_wr_q <= cp_rd_q) && (cp_rd_q <= cp_size_q)))
		else $error("copy pointers out of order");

	// A latched packet flips the receive bank
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_accept && latch) |=> (wbank_q != $past(wbank_q)))
		else $error("receive bank did not flip");

	// A completed packet reports the same size as the latched size
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && done_q) |-> ((size_q == lsize_q) && (size_q != 9'd0)))
		else $error("packet size mismatch");

	// Frame position never runs past the largest packet
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < MAX_PACKET_BYTES)
		else $error("frame position overrun");

endmodule

[rtl/xcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module xcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read the old contents at the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
